FILE: hw/rtl/lcdseq_pkg.sv
// Shared types, constants and the control store of the character LCD command sequencer.
package lcdseq_pkg;

  // Default width of the number that is printed in decimal.
  localparam int NUMBER_BITS_DEF = 32;

  // Width of the step counter of the control store.
  localparam int PC_W = 5;

  // Number of pattern rows in one custom glyph.
  localparam int GLYPH_ROWS = 8;

  // Request codes.
  typedef enum logic [2:0] {
    CMD_INSTR  = 3'd0,
    CMD_DATA   = 3'd1,
    CMD_INIT   = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_NUMBER = 3'd4,
    CMD_GLYPH  = 3'd5
  } cmd_t;

  // Bytes and nibbles the display expects.
  localparam logic [7:0] FUNC_SET_8BIT = 8'b0011_1000;
  localparam logic [7:0] DISPLAY_ON    = 8'b0000_1100;
  localparam logic [7:0] CLEAR_DISPLAY = 8'b0000_0001;
  localparam logic [3:0] NIB_FUNC_4BIT = 4'b0010;
  localparam logic [3:0] NIB_TWO_LINES = 4'b1000;
  localparam logic [7:0] CGRAM_SET     = 8'h40;
  localparam logic [7:0] DDRAM_SET     = 8'h80;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_MINUS   = 8'h2D;

  // Operation of one control word.
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_EMIT    = 3'd1,
    OP_RAW     = 3'd2,
    OP_CONVERT = 3'd3,
    OP_SKIP    = 3'd4
  } op_t;

  // Source of the byte that a transfer carries.
  typedef enum logic [2:0] {
    SRC_CONST   = 3'd0,
    SRC_BYTE    = 3'd1,
    SRC_CURSOR  = 3'd2,
    SRC_GLYPH   = 3'd3,
    SRC_PATTERN = 3'd4,
    SRC_SLOT    = 3'd5,
    SRC_DIGIT   = 3'd6
  } src_t;

  // Jump conditions, tested when a word completes.
  typedef enum logic [2:0] {
    COND_NONE   = 3'd0,
    COND_ALWAYS = 3'd1,
    COND_MODE8  = 3'd2,
    COND_POS    = 3'd3,
    COND_LOOP   = 3'd4
  } cond_t;

  // Marks the word whose final transfer ends the request.
  typedef enum logic [1:0] {
    FIN_NO   = 2'd0,
    FIN_YES  = 2'd1,
    FIN_LOOP = 2'd2
  } fin_t;

  typedef struct packed {
    op_t             op;
    src_t            src;
    logic            rs;
    logic [7:0]      konst;
    cond_t           cond;
    logic [PC_W-1:0] target;
    fin_t            fin;
    logic            step;
  } ucode_t;

  // Control signals from the sequencer to the datapath.
  typedef struct packed {
    logic       strobe;
    logic       last;
    logic       rs;
    logic       raw;
    logic       nibble;
    logic       phase;
    logic       step;
    src_t       src;
    logic [7:0] konst;
  } ctrl_t;

  // Status of the decimal converter.
  typedef struct packed {
    logic done;
    logic top_zero;
    logic neg;
  } bcd_stat_t;

  // Entry points of the program.
  localparam logic [PC_W-1:0] W_INSTR  = 5'd0;
  localparam logic [PC_W-1:0] W_DATA   = 5'd1;
  localparam logic [PC_W-1:0] W_INIT   = 5'd2;
  localparam logic [PC_W-1:0] W_INIT8  = 5'd6;
  localparam logic [PC_W-1:0] W_INITON = 5'd7;
  localparam logic [PC_W-1:0] W_CURSOR = 5'd9;
  localparam logic [PC_W-1:0] W_NUMBER = 5'd10;
  localparam logic [PC_W-1:0] W_DIGITS = 5'd14;
  localparam logic [PC_W-1:0] W_GLYPH  = 5'd15;
  localparam logic [PC_W-1:0] W_ROWS   = 5'd16;

  function automatic ucode_t uw(op_t op, src_t src, logic rs, logic [7:0] konst,
                                cond_t cond, logic [PC_W-1:0] target, fin_t fin,
                                logic step);
    ucode_t w;
    w.op     = op;
    w.src    = src;
    w.rs     = rs;
    w.konst  = konst;
    w.cond   = cond;
    w.target = target;
    w.fin    = fin;
    w.step   = step;
    return w;
  endfunction

  // The control store: one word per step.
  function automatic ucode_t ucode(logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:  w = uw(OP_EMIT, SRC_BYTE, 1'b0, 8'h00, COND_NONE, W_INSTR, FIN_YES, 1'b0);
      5'd1:  w = uw(OP_EMIT, SRC_BYTE, 1'b1, 8'h00, COND_NONE, W_INSTR, FIN_YES, 1'b0);
      // Init: four-bit mode sends three raw nibbles first.
      5'd2:  w = uw(OP_NOP, SRC_CONST, 1'b0, 8'h00, COND_MODE8, W_INIT8, FIN_NO, 1'b0);
      5'd3:  w = uw(OP_RAW, SRC_CONST, 1'b0, {4'h0, NIB_FUNC_4BIT}, COND_NONE, W_INSTR,
                    FIN_NO, 1'b0);
      5'd4:  w = uw(OP_RAW, SRC_CONST, 1'b0, {4'h0, NIB_FUNC_4BIT}, COND_NONE, W_INSTR,
                    FIN_NO, 1'b0);
      5'd5:  w = uw(OP_RAW, SRC_CONST, 1'b0, {4'h0, NIB_TWO_LINES}, COND_ALWAYS, W_INITON,
                    FIN_NO, 1'b0);
      5'd6:  w = uw(OP_EMIT, SRC_CONST, 1'b0, FUNC_SET_8BIT, COND_NONE, W_INSTR, FIN_NO, 1'b0);
      5'd7:  w = uw(OP_EMIT, SRC_CONST, 1'b0, DISPLAY_ON, COND_NONE, W_INSTR, FIN_NO, 1'b0);
      5'd8:  w = uw(OP_EMIT, SRC_CONST, 1'b0, CLEAR_DISPLAY, COND_NONE, W_INSTR, FIN_YES, 1'b0);
      5'd9:  w = uw(OP_EMIT, SRC_CURSOR, 1'b0, 8'h00, COND_NONE, W_INSTR, FIN_YES, 1'b0);
      // Number: convert, drop leading zeros, optional minus, then the digits.
      5'd10: w = uw(OP_CONVERT, SRC_CONST, 1'b0, 8'h00, COND_NONE, W_INSTR, FIN_NO, 1'b0);
      5'd11: w = uw(OP_SKIP, SRC_CONST, 1'b0, 8'h00, COND_NONE, W_INSTR, FIN_NO, 1'b0);
      5'd12: w = uw(OP_NOP, SRC_CONST, 1'b0, 8'h00, COND_POS, W_DIGITS, FIN_NO, 1'b0);
      5'd13: w = uw(OP_EMIT, SRC_CONST, 1'b1, ASCII_MINUS, COND_NONE, W_INSTR, FIN_NO, 1'b0);
      5'd14: w = uw(OP_EMIT, SRC_DIGIT, 1'b1, 8'h00, COND_LOOP, W_DIGITS, FIN_LOOP, 1'b1);
      // Custom glyph: CGRAM address, eight rows, cursor, then the glyph itself.
      5'd15: w = uw(OP_EMIT, SRC_GLYPH, 1'b0, 8'h00, COND_NONE, W_INSTR, FIN_NO, 1'b0);
      5'd16: w = uw(OP_EMIT, SRC_PATTERN, 1'b1, 8'h00, COND_LOOP, W_ROWS, FIN_NO, 1'b1);
      5'd17: w = uw(OP_EMIT, SRC_CURSOR, 1'b0, 8'h00, COND_NONE, W_INSTR, FIN_NO, 1'b0);
      5'd18: w = uw(OP_EMIT, SRC_SLOT, 1'b1, 8'h00, COND_NONE, W_INSTR, FIN_YES, 1'b0);
      default: w = uw(OP_NOP, SRC_CONST, 1'b0, 8'h00, COND_NONE, W_INSTR, FIN_YES, 1'b0);
    endcase
    return w;
  endfunction

  // First step of each request.
  function automatic logic [PC_W-1:0] entry(cmd_t cmd);
    logic [PC_W-1:0] pc;
    case (cmd)
      CMD_INSTR:  pc = W_INSTR;
      CMD_DATA:   pc = W_DATA;
      CMD_INIT:   pc = W_INIT;
      CMD_CURSOR: pc = W_CURSOR;
      CMD_NUMBER: pc = W_NUMBER;
      CMD_GLYPH:  pc = W_GLYPH;
      default:    pc = W_INSTR;
    endcase
    return pc;
  endfunction

endpackage

FILE: hw/rtl/lcdseq_bcd.sv
// Binary to decimal converter with a digit shifter, most significant digit on top.
module lcdseq_bcd #(
  parameter int NUMBER_BITS = lcdseq_pkg::NUMBER_BITS_DEF,
  parameter int DIGITS      = (lcdseq_pkg::NUMBER_BITS_DEF * 3) / 10 + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [NUMBER_BITS-1:0] raw,
  input  logic                   step,
  output logic [3:0]             digit,
  output lcdseq_pkg::bcd_stat_t  stat
);

  localparam int CntW = $clog2(NUMBER_BITS + 1);
  localparam int BcdW = DIGITS * 4;

  logic [NUMBER_BITS-1:0] bin_r;
  logic [BcdW-1:0]        bcd_r;
  logic [BcdW-1:0]        adj;
  logic                   neg_r;
  logic [CntW-1:0]        cnt_r;
  logic [NUMBER_BITS-1:0] mag;

  // Magnitude of the two's complement value; the most negative value maps onto itself.
  assign mag = raw[NUMBER_BITS-1] ? (~raw + 1'b1) : raw;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  // One shift per cycle while converting; afterwards each step drops the top digit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= CntW'(NUMBER_BITS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin_r <= mag;
      bcd_r <= '0;
      neg_r <= raw[NUMBER_BITS-1];
    end else if (cnt_r != '0) begin
      {bcd_r, bin_r} <= {adj[BcdW-2:0], bin_r, 1'b0};
    end else if (step) begin
      bcd_r <= {bcd_r[BcdW-5:0], 4'h0};
    end
  end

  assign digit         = bcd_r[BcdW-1 -: 4];
  assign stat.done     = (cnt_r == '0);
  assign stat.top_zero = (digit == 4'h0);
  assign stat.neg      = neg_r;

endmodule

FILE: hw/rtl/lcdseq_seq.sv
// Microcoded sequencer: step counter, nibble phase, loop counter and jump logic.
module lcdseq_seq #(
  parameter int DIGITS = (lcdseq_pkg::NUMBER_BITS_DEF * 3) / 10 + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [2:0]            cmd,
  input  logic                  bus_mode,
  input  lcdseq_pkg::bcd_stat_t stat,
  output logic                  busy,
  output lcdseq_pkg::ctrl_t     ctrl
);

  localparam int MaxCnt = (DIGITS > lcdseq_pkg::GLYPH_ROWS) ? DIGITS : lcdseq_pkg::GLYPH_ROWS;
  localparam int CntW   = $clog2(MaxCnt + 1);

  logic                        busy_r, busy_nxt;
  logic [lcdseq_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                        phase_r, phase_nxt;
  logic [CntW-1:0]             cnt_r, cnt_nxt;

  lcdseq_pkg::ucode_t w;
  lcdseq_pkg::cmd_t   cmd_e;
  logic               strobe;
  logic               done;
  logic               skip_shift;
  logic               fin_now;
  logic               cond_true;
  logic               step;

  assign w     = lcdseq_pkg::ucode(pc_r);
  assign cmd_e = lcdseq_pkg::cmd_t'(cmd);

  // Completion of the current word and whether it ends the request.
  always_comb begin
    strobe     = 1'b0;
    done       = 1'b0;
    skip_shift = 1'b0;
    case (w.op)
      lcdseq_pkg::OP_EMIT: begin
        strobe = 1'b1;
        done   = !bus_mode || phase_r;
      end
      lcdseq_pkg::OP_RAW: begin
        strobe = 1'b1;
        done   = 1'b1;
      end
      lcdseq_pkg::OP_CONVERT: begin
        done = stat.done;
      end
      lcdseq_pkg::OP_SKIP: begin
        skip_shift = stat.top_zero && (cnt_r > CntW'(1));
        done       = !skip_shift;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    strobe     = strobe && busy_r;
    done       = done && busy_r;
    skip_shift = skip_shift && busy_r;

    case (w.fin)
      lcdseq_pkg::FIN_YES:  fin_now = 1'b1;
      lcdseq_pkg::FIN_LOOP: fin_now = (cnt_r == CntW'(1));
      default:              fin_now = 1'b0;
    endcase

    case (w.cond)
      lcdseq_pkg::COND_ALWAYS: cond_true = 1'b1;
      lcdseq_pkg::COND_MODE8:  cond_true = !bus_mode;
      lcdseq_pkg::COND_POS:    cond_true = !stat.neg;
      lcdseq_pkg::COND_LOOP:   cond_true = (cnt_r != CntW'(1));
      default:                 cond_true = 1'b0;
    endcase

    step = (done && w.step) || skip_shift;
  end

  // Next step: start a request, split bytes into nibbles, jump or advance.
  always_comb begin
    busy_nxt  = busy_r;
    pc_nxt    = pc_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      busy_nxt  = (cmd_e == lcdseq_pkg::CMD_INSTR) || (cmd_e == lcdseq_pkg::CMD_DATA) ||
                  (cmd_e == lcdseq_pkg::CMD_INIT) || (cmd_e == lcdseq_pkg::CMD_CURSOR) ||
                  (cmd_e == lcdseq_pkg::CMD_NUMBER) || (cmd_e == lcdseq_pkg::CMD_GLYPH);
      pc_nxt    = lcdseq_pkg::entry(cmd_e);
      phase_nxt = 1'b0;
      cnt_nxt   = (cmd_e == lcdseq_pkg::CMD_NUMBER) ? CntW'(DIGITS)
                                                    : CntW'(lcdseq_pkg::GLYPH_ROWS);
    end else if (busy_r) begin
      if (step) begin
        cnt_nxt = cnt_r - 1'b1;
      end
      if (strobe && !done) begin
        phase_nxt = 1'b1;
      end
      if (done) begin
        phase_nxt = 1'b0;
        if (fin_now) begin
          busy_nxt = 1'b0;
        end else if (cond_true) begin
          pc_nxt = w.target;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pc_r    <= lcdseq_pkg::W_INSTR;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      pc_r    <= pc_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy        = busy_r;
  assign ctrl.strobe = strobe;
  assign ctrl.last   = strobe && done && fin_now;
  assign ctrl.rs     = w.rs;
  assign ctrl.raw    = (w.op == lcdseq_pkg::OP_RAW);
  assign ctrl.nibble = bus_mode;
  assign ctrl.phase  = phase_r;
  assign ctrl.step   = step;
  assign ctrl.src    = w.src;
  assign ctrl.konst  = w.konst;

endmodule

FILE: hw/rtl/char_lcd_command_sequencer_core.sv
// Top level of the character LCD command sequencer: request registers and transfer output.
//
//   Channel  Ports                                          Transfer when
//   request  start, busy, in_command .. in_glyph_pattern    start high while busy low
//   result   out_strobe, out_reg_select, out_bus_value,     every cycle out_strobe is high
//            out_last
//   config   cfg_valid, cfg_ready, cfg_bus_mode             cfg_valid and cfg_ready high
//
// The sequencer issues at most one bus transfer per cycle: one per emitting control word in
// eight-bit mode and two per emitting word in four-bit mode; a raw nibble word issues one.
// A number runs the shift-and-add converter first, then drops leading zero digits and
// sends an optional minus before its digits go out.
// Reset clears the bus mode to eight-bit; results appear in the cycle after they are formed,
// from the output register, and the receiver cannot stall them.
module char_lcd_command_sequencer_core #(
  parameter int NUMBER_BITS = lcdseq_pkg::NUMBER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_byte_value,
  input  logic [5:0]  in_column,
  input  logic        in_row,
  input  logic signed [31:0] in_number,
  input  logic [2:0]  in_glyph_slot,
  input  logic [63:0] in_glyph_pattern,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_bus_mode,
  output logic        out_strobe,
  output logic        out_reg_select,
  output logic [7:0]  out_bus_value,
  output logic        out_last
);

  localparam int Digits = (NUMBER_BITS * 3) / 10 + 1;

  logic                  accept;
  logic                  seq_busy;
  logic                  bus_mode_r;
  logic [7:0]            byte_r;
  logic [5:0]            column_r;
  logic                  row_r;
  logic [2:0]            slot_r;
  logic [63:0]           pattern_r;
  logic [3:0]            digit;
  logic [7:0]            src_byte;
  logic [7:0]            bus_nxt;
  logic                  out_strobe_r, out_reg_select_r, out_last_r;
  logic [7:0]            out_bus_value_r;
  lcdseq_pkg::ctrl_t     ctrl;
  lcdseq_pkg::bcd_stat_t stat;

  assign accept    = start && !seq_busy;
  assign busy      = seq_busy;
  assign cfg_ready = !seq_busy;

  // Bus mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      bus_mode_r <= cfg_bus_mode;
    end
  end

  // Request fields; the pattern shifts down one row per row transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r    <= in_byte_value;
      column_r  <= in_column;
      row_r     <= in_row;
      slot_r    <= in_glyph_slot;
      pattern_r <= in_glyph_pattern;
    end else if (ctrl.step) begin
      pattern_r <= {8'h00, pattern_r[63:8]};
    end
  end

  lcdseq_bcd #(
    .NUMBER_BITS (NUMBER_BITS),
    .DIGITS      (Digits)
  ) u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept && (in_command == lcdseq_pkg::CMD_NUMBER)),
    .raw   (in_number[NUMBER_BITS-1:0]),
    .step  (ctrl.step),
    .digit (digit),
    .stat  (stat)
  );

  lcdseq_seq #(
    .DIGITS (Digits)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .cmd      (in_command),
    .bus_mode (bus_mode_r),
    .stat     (stat),
    .busy     (seq_busy),
    .ctrl     (ctrl)
  );

  // Byte source selection.
  always_comb begin
    case (ctrl.src)
      lcdseq_pkg::SRC_BYTE:    src_byte = byte_r;
      lcdseq_pkg::SRC_CURSOR:  src_byte = lcdseq_pkg::DDRAM_SET | {1'b0, row_r, column_r};
      lcdseq_pkg::SRC_GLYPH:   src_byte = lcdseq_pkg::CGRAM_SET | {2'b00, slot_r, 3'b000};
      lcdseq_pkg::SRC_PATTERN: src_byte = pattern_r[7:0];
      lcdseq_pkg::SRC_SLOT:    src_byte = {5'b00000, slot_r};
      lcdseq_pkg::SRC_DIGIT:   src_byte = lcdseq_pkg::ASCII_ZERO | {4'h0, digit};
      default:                 src_byte = ctrl.konst;
    endcase
  end

  // Raw nibble, high or low nibble, or the whole byte.
  always_comb begin
    if (ctrl.raw) begin
      bus_nxt = {4'h0, ctrl.konst[3:0]};
    end else if (ctrl.nibble) begin
      bus_nxt = ctrl.phase ? {4'h0, src_byte[3:0]} : {4'h0, src_byte[7:4]};
    end else begin
      bus_nxt = src_byte;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.strobe;
      out_last_r   <= ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    out_reg_select_r <= ctrl.rs && !ctrl.raw;
    out_bus_value_r  <= bus_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_reg_select = out_reg_select_r;
  assign out_bus_value  = out_bus_value_r;
  assign out_last       = out_last_r;

endmodule

FILE: hw/rtl/lcdseq_chk.sv
// Port-level checker of the character LCD command sequencer and its bind.
module lcdseq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_reg_select,
  input logic [7:0]  out_bus_value,
  input logic        out_last
);

  // The final flag only marks a real transfer.
  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe)
    else $error("final flag without a transfer");

  // A transfer that is not the final one leaves the block busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> busy)
    else $error("block idle in the middle of a request");

  // The block goes idle exactly as the final transfer appears.
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_last)
    else $error("busy fell without a final transfer");

  // A new request cannot produce a transfer in the cycle after the final one.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_strobe)
    else $error("transfer right after the final one");

  // Every transfer carries defined values.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown({out_reg_select, out_bus_value, out_last}))
    else $error("transfer with undefined values");

endmodule

bind char_lcd_command_sequencer_core lcdseq_chk u_lcdseq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_reg_select (out_reg_select),
  .out_bus_value  (out_bus_value),
  .out_last       (out_last)
);
